### sv/uripd_pkg.sv
// uripd_pkg: types, character constants and hex helpers for the URI percent decoder.
// No dependencies.
package uripd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int MAX_RESULTS = 3;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // pending codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        item_t [MAX_RESULTS-1:0] items;
    } step_t;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
              || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        hex_val = v[3:0];
    endfunction

    function automatic logic [7:0] map_plain(input logic [7:0] c);
        map_plain = (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

### sv/uripd_step.sv
// uripd_step: combinational decode of one input byte against the pending state.
// Produces up to three result bytes and the next state. Depends on uripd_pkg.
module uripd_step
    import uripd_pkg::*;
(
    input  logic [1:0] pend,
    input  logic [7:0] held,
    input  logic [7:0] in_data,
    input  logic       in_last,
    output step_t      res,
    output logic [1:0] pend_next,
    output logic [7:0] held_next
);

    logic [1:0] n;
    logic [1:0] pc;
    logic [7:0] hd;
    logic       esc_ok;

    always_comb
    begin
        res    = '0;
        n      = 2'd0;
        pc     = pend;
        hd     = held;
        esc_ok = hex_ok(held) && hex_ok(in_data) && ({hex_val(held), hex_val(in_data)} != 8'h00);

        unique case (pc)
            PEND_PCT:
            begin
                hd = in_data;
                pc = PEND_DIGIT;
            end
            PEND_DIGIT:
            begin
                if (esc_ok)
                begin
                    res.items[n].data = {hex_val(held), hex_val(in_data)};
                    n  = n + 2'd1;
                    pc = PEND_NONE;
                    hd = 8'h00;
                end
                else
                begin
                    res.items[n].data = CH_PERCENT;
                    n = n + 2'd1;
                    if (held == CH_PERCENT)
                    begin
                        // held percent restarts an escape; the new byte becomes its digit
                        hd = in_data;
                        pc = PEND_DIGIT;
                    end
                    else
                    begin
                        res.items[n].data = map_plain(held);
                        n  = n + 2'd1;
                        hd = 8'h00;
                        if (in_data == CH_PERCENT)
                        begin
                            pc = PEND_PCT;
                        end
                        else
                        begin
                            res.items[n].data = map_plain(in_data);
                            n  = n + 2'd1;
                            pc = PEND_NONE;
                        end
                    end
                end
            end
            default:
            begin
                if (in_data == CH_PERCENT)
                begin
                    pc = PEND_PCT;
                end
                else
                begin
                    res.items[n].data = map_plain(in_data);
                    n  = n + 2'd1;
                    pc = PEND_NONE;
                end
            end
        endcase

        // end of string: flush anything pending
        if (in_last)
        begin
            if (pc == PEND_PCT)
            begin
                res.items[n].data = CH_PERCENT;
                n = n + 2'd1;
            end
            else if (pc == PEND_DIGIT)
            begin
                res.items[n].data = CH_PERCENT;
                n = n + 2'd1;
                res.items[n].data = (hd == CH_PERCENT) ? CH_PERCENT : map_plain(hd);
                n  = n + 2'd1;
                hd = 8'h00;
            end
            pc = PEND_NONE;
            res.items[n - 2'd1].last = 1'b1;
        end

        res.count = n;
        pend_next = pc;
        held_next = hd;
    end

endmodule

### sv/uripd_queue.sv
// uripd_queue: small result queue taking up to three entries a cycle, one out.
// Entries leave only while out_ready is high. Depends on uripd_pkg.
module uripd_queue
    import uripd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  step_t      push_res,
    output logic       space,
    output logic       out_valid,
    input  logic       out_ready,
    output item_t      out_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n    = push ? push_res.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign space     = cnt_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + QIDX_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QIDX_W'(pop);
    assign cnt_next    = cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                mem_reg[wr_ptr_reg + QIDX_W'(i)] <= push_res.items[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### sv/uri_percent_decoder.sv
// uri_percent_decoder: top level, percent and plus decoding of a URI byte stream.
// Depends on uripd_pkg, uripd_step and uripd_queue.
//
//  channel   dir  tdata          tlast
//  s_*       in   in_byte[7:0]   in_last
//  m_*       out  out_byte[7:0]  out_last
//
// One request taken per cycle while the result queue has room for three entries.
// A request yields 0..3 results; they are written into the queue and leave it at one per
// cycle while m_tready is high. Sustained input rate is bounded by the output rate.
// Reset clears the pending state and empties the queue. m_tready low backs up the queue
// and then drops s_tready.
module uri_percent_decoder
    import uripd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    step_t      res;
    item_t      head;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    uripd_step u_step (
        .pend      (pend_reg),
        .held      (held_reg),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .res       (res),
        .pend_next (pend_next),
        .held_next (held_next)
    );

    uripd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_res  (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = head.data;
    assign m_tlast = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

endmodule
